// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the list checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion held off while reset is high
`define IDLL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// assertion checked at every edge, reset included
`define IDLL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== hdl/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// types and codes shared by the indexed doubly linked list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

   localparam int ACTION_W   = 3;
   localparam int ID_FIELD_W = 10;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int WIDE_W     = 17;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_MOVE   = 3'd2,
      ACT_SPLICE = 3'd3,
      ACT_READ   = 3'd4,
      ACT_REMOVE = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_A,
      S_RD_B,
      S_PLAN,
      S_WR0,
      S_WR1,
      S_WR2
   } state_type;

   typedef struct packed {
      status_type status;
      logic [1:0] next_we;
      logic [2:0] prev_we;
      logic       pres_we;
      logic       pres_data;
      logic       value_we;
      logic       next_exists;
      logic       prev_exists;
   } plan_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/indexed_doubly_linked_list.sv =====
// an accepted request walks the read-a, read-b and plan steps, and rsp_valid is
//    registered as the plan step fires; no new request is taken until the three
//    write steps through the one-write-port link, value and presence rams end;
//    a stalled response holds the plan step until it is taken
// reset: synchronous; head and tail go null, then a clearing pass over every entry
//    zeroes the presence ram while req_stall stays high
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// id-addressed doubly linked list with value store and link queries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_doubly_linked_list #(
   parameter int NODE_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [idll_pkg::ACTION_W-1:0]       req_action,
   input  logic [idll_pkg::ID_FIELD_W-1:0]     req_node_id,
   input  logic [idll_pkg::ID_FIELD_W-1:0]     req_other_id,
   input  logic signed [idll_pkg::VALUE_W-1:0] req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [idll_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [idll_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [idll_pkg::ID_FIELD_W-1:0]     rsp_next_id,
   output logic                                rsp_next_exists,
   output logic [idll_pkg::ID_FIELD_W-1:0]     rsp_prev_id,
   output logic                                rsp_prev_exists,
   output logic [idll_pkg::ID_FIELD_W-1:0]     rsp_head_id,
   output logic [idll_pkg::ID_FIELD_W-1:0]     rsp_tail_id,
   output logic                                rsp_list_empty
);

   import idll_pkg::*;

   localparam int ID_W = $clog2(NODE_COUNT);
   localparam logic [ID_W-1:0] LAST_IDX = ID_W'(NODE_COUNT - 1);

   state_type state_ff, state_in;
   logic [ID_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ID_W:0]   head_ff, head_in, tail_ff, tail_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            plan_fire;

   logic [ACTION_W-1:0] action_ff;
   logic [ID_W-1:0]     a_idx_ff, b_idx_ff;
   logic                a_ok_ff, b_ok_ff;
   logic [VALUE_W-1:0]  item_ff;
   logic                pres_a_ff;
   logic [VALUE_W-1:0]  val_a_ff;
   logic [ID_W:0]       next_a_ff, prev_a_ff;

   logic [WIDE_W-1:0]   node_wide, other_wide;

   plan_ctl_type    plan_ctl, ctl_ff;
   logic [ID_W-1:0] plan_next_addr [2];
   logic [ID_W:0]   plan_next_data [2];
   logic [ID_W-1:0] plan_prev_addr [3];
   logic [ID_W:0]   plan_prev_data [3];
   logic [ID_W:0]   plan_head, plan_tail;
   logic [VALUE_W-1:0] plan_rd_value;
   logic [ID_W-1:0] plan_rd_next, plan_rd_prev;

   logic [ID_W-1:0] next_addr_ff [2];
   logic [ID_W:0]   next_data_ff [2];
   logic [ID_W-1:0] prev_addr_ff [3];
   logic [ID_W:0]   prev_data_ff [3];

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [ID_FIELD_W-1:0] rsp_next_ff, rsp_prev_ff, rsp_head_ff, rsp_tail_ff;
   logic                  rsp_nex_ff, rsp_pex_ff, rsp_empty_ff;

   logic            rd_pres;
   logic [VALUE_W-1:0] rd_val;
   logic [ID_W:0]   rd_next, rd_prev;
   logic [ID_W-1:0] rd_addr;

   logic            pres_we, pres_wd;
   logic [ID_W-1:0] pres_wa;
   logic            val_we;
   logic            nx_we;
   logic [ID_W-1:0] nx_wa;
   logic [ID_W:0]   nx_wd;
   logic            pv_we;
   logic [ID_W-1:0] pv_wa;
   logic [ID_W:0]   pv_wd;

   assign node_wide  = {{(WIDE_W-ID_FIELD_W){1'b0}}, req_node_id};
   assign other_wide = {{(WIDE_W-ID_FIELD_W){1'b0}}, req_other_id};
   assign req_stall  = (state_ff != S_IDLE);
   assign plan_fire  = (state_ff == S_PLAN) && !(rsp_valid_ff && rsp_stall);
   assign rd_addr    = (state_ff == S_RD_A) ? a_idx_ff : b_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         head_ff      <= {1'b1, {ID_W{1'b0}}};
         tail_ff      <= {1'b1, {ID_W{1'b0}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      head_in      = plan_fire ? plan_head : head_ff;
      tail_in      = plan_fire ? plan_tail : tail_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (plan_fire) begin
         rsp_valid_in = 1'b1;
      end
      pres_we = 1'b0;
      pres_wa = a_idx_ff;
      pres_wd = ctl_ff.pres_data;
      val_we  = 1'b0;
      nx_we   = 1'b0;
      nx_wa   = next_addr_ff[0];
      nx_wd   = next_data_ff[0];
      pv_we   = 1'b0;
      pv_wa   = prev_addr_ff[0];
      pv_wd   = prev_data_ff[0];
      case (state_ff)
         S_CLEAR: begin
            pres_we    = 1'b1;
            pres_wa    = clr_cnt_ff;
            pres_wd    = 1'b0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            state_in = S_RD_B;
         end
         S_RD_B: begin
            state_in = S_PLAN;
         end
         S_PLAN: begin
            if (plan_fire) begin
               state_in = S_WR0;
            end
         end
         S_WR0: begin
            pres_we  = ctl_ff.pres_we;
            val_we   = ctl_ff.value_we;
            nx_we    = ctl_ff.next_we[0];
            pv_we    = ctl_ff.prev_we[0];
            state_in = S_WR1;
         end
         S_WR1: begin
            nx_we    = ctl_ff.next_we[1];
            nx_wa    = next_addr_ff[1];
            nx_wd    = next_data_ff[1];
            pv_we    = ctl_ff.prev_we[1];
            pv_wa    = prev_addr_ff[1];
            pv_wd    = prev_data_ff[1];
            state_in = S_WR2;
         end
         S_WR2: begin
            pv_we    = ctl_ff.prev_we[2];
            pv_wa    = prev_addr_ff[2];
            pv_wd    = prev_data_ff[2];
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         action_ff <= req_action;
         a_idx_ff  <= ID_W'(node_wide);
         b_idx_ff  <= ID_W'(other_wide);
         a_ok_ff   <= (node_wide < WIDE_W'(NODE_COUNT));
         b_ok_ff   <= (other_wide < WIDE_W'(NODE_COUNT));
         item_ff   <= req_item_value;
      end
      if (state_ff == S_RD_B) begin
         pres_a_ff <= rd_pres;
         val_a_ff  <= rd_val;
         next_a_ff <= rd_next;
         prev_a_ff <= rd_prev;
      end
      if (plan_fire) begin
         ctl_ff       <= plan_ctl;
         next_addr_ff <= plan_next_addr;
         next_data_ff <= plan_next_data;
         prev_addr_ff <= plan_prev_addr;
         prev_data_ff <= plan_prev_data;
         rsp_status_ff <= plan_ctl.status;
         rsp_value_ff  <= plan_rd_value;
         rsp_next_ff   <= ID_FIELD_W'(plan_rd_next);
         rsp_prev_ff   <= ID_FIELD_W'(plan_rd_prev);
         rsp_nex_ff    <= plan_ctl.next_exists;
         rsp_pex_ff    <= plan_ctl.prev_exists;
         rsp_head_ff   <= plan_head[ID_W] ? '0 : ID_FIELD_W'(plan_head[ID_W-1:0]);
         rsp_tail_ff   <= plan_tail[ID_W] ? '0 : ID_FIELD_W'(plan_tail[ID_W-1:0]);
         rsp_empty_ff  <= plan_head[ID_W];
      end
   end

   idll_plan #(.ID_W(ID_W)) u_plan (
      .action    (action_ff),
      .a_idx     (a_idx_ff),
      .b_idx     (b_idx_ff),
      .a_ok      (a_ok_ff),
      .b_ok      (b_ok_ff),
      .pres_a    (pres_a_ff),
      .pres_b    (rd_pres),
      .next_a    (next_a_ff),
      .prev_a    (prev_a_ff),
      .next_b    (rd_next),
      .value_a   (val_a_ff),
      .head      (head_ff),
      .tail      (tail_ff),
      .ctl       (plan_ctl),
      .next_addr (plan_next_addr),
      .next_data (plan_next_data),
      .prev_addr (plan_prev_addr),
      .prev_data (plan_prev_data),
      .new_head  (plan_head),
      .new_tail  (plan_tail),
      .rd_value  (plan_rd_value),
      .rd_next   (plan_rd_next),
      .rd_prev   (plan_rd_prev)
   );

   idll_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_pres_ram (
      .clock   (clock),
      .wr_en   (pres_we),
      .wr_addr (pres_wa),
      .wr_data (pres_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_pres)
   );

   idll_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_COUNT)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (a_idx_ff),
      .wr_data (item_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_val)
   );

   idll_ram #(.WIDTH(ID_W + 1), .DEPTH(NODE_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_wa),
      .wr_data (nx_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_next)
   );

   idll_ram #(.WIDTH(ID_W + 1), .DEPTH(NODE_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_wa),
      .wr_data (pv_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_prev)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_next_id     = rsp_next_ff;
   assign rsp_next_exists = rsp_nex_ff;
   assign rsp_prev_id     = rsp_prev_ff;
   assign rsp_prev_exists = rsp_pex_ff;
   assign rsp_head_id     = rsp_head_ff;
   assign rsp_tail_id     = rsp_tail_ff;
   assign rsp_list_empty  = rsp_empty_ff;

endmodule

`default_nettype wire

// ===== hdl/idll_ram.sv =====
// ----------------------------------------------------------------------------
// idll_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/idll_plan.sv =====
// ----------------------------------------------------------------------------
// idll_plan
// decides status, presence, value and link writes, read results and new head and tail for one action
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idll_plan #(
   parameter int ID_W = 10
) (
   input  logic [idll_pkg::ACTION_W-1:0] action,
   input  logic [ID_W-1:0]               a_idx,
   input  logic [ID_W-1:0]               b_idx,
   input  logic                          a_ok,
   input  logic                          b_ok,
   input  logic                          pres_a,
   input  logic                          pres_b,
   input  logic [ID_W:0]                 next_a,
   input  logic [ID_W:0]                 prev_a,
   input  logic [ID_W:0]                 next_b,
   input  logic [idll_pkg::VALUE_W-1:0]  value_a,
   input  logic [ID_W:0]                 head,
   input  logic [ID_W:0]                 tail,
   output idll_pkg::plan_ctl_type        ctl,
   output logic [ID_W-1:0]               next_addr [2],
   output logic [ID_W:0]                 next_data [2],
   output logic [ID_W-1:0]               prev_addr [3],
   output logic [ID_W:0]                 prev_data [3],
   output logic [ID_W:0]                 new_head,
   output logic [ID_W:0]                 new_tail,
   output logic [idll_pkg::VALUE_W-1:0]  rd_value,
   output logic [ID_W-1:0]               rd_next,
   output logic [ID_W-1:0]               rd_prev
);

   import idll_pkg::*;

   logic [ID_W:0]   lnk_a;
   logic [ID_W:0]   lnk_b;
   logic [ID_W:0]   lnk_null;
   logic [ID_W:0]   lnk_e;
   logic [ID_W:0]   mv_n;
   logic [ID_W-1:0] e_idx;
   logic            a_here;
   logic            b_here;

   assign lnk_a    = {1'b0, a_idx};
   assign lnk_b    = {1'b0, b_idx};
   assign lnk_null = {1'b1, {ID_W{1'b0}}};
   assign e_idx    = (action == ACT_MOVE) ? a_idx : b_idx;
   assign lnk_e    = {1'b0, e_idx};
   assign mv_n     = (action == ACT_MOVE) ? next_a : next_b;
   assign a_here   = a_ok && pres_a;
   assign b_here   = b_ok && pres_b;

   always_comb begin
      ctl        = '0;
      ctl.status = ST_DONE;
      for (int i = 0; i < 2; i++) begin
         next_addr[i] = a_idx;
         next_data[i] = lnk_null;
      end
      for (int i = 0; i < 3; i++) begin
         prev_addr[i] = a_idx;
         prev_data[i] = lnk_null;
      end
      new_head = head;
      new_tail = tail;
      rd_value = '0;
      rd_next  = '0;
      rd_prev  = '0;
      case (action)
         ACT_APPEND: begin
            if (!a_ok) begin
               ctl.status = ST_NOT_FOUND;
            end else if (pres_a) begin
               ctl.status = ST_DUPLICATE;
            end else begin
               ctl.pres_we   = 1'b1;
               ctl.pres_data = 1'b1;
               ctl.value_we  = 1'b1;
               ctl.prev_we[0] = 1'b1;
               prev_data[0]   = tail;
               ctl.next_we[0] = 1'b1;
               next_data[0]   = lnk_null;
               if (!tail[ID_W]) begin
                  ctl.next_we[1] = 1'b1;
                  next_addr[1]   = tail[ID_W-1:0];
                  next_data[1]   = lnk_a;
               end else begin
                  new_head = lnk_a;
               end
               new_tail = lnk_a;
            end
         end
         ACT_INSERT: begin
            if (!b_here || !a_ok) begin
               ctl.status = ST_NOT_FOUND;
            end else if (pres_a) begin
               ctl.status = ST_DUPLICATE;
            end else begin
               ctl.pres_we    = 1'b1;
               ctl.pres_data  = 1'b1;
               ctl.value_we   = 1'b1;
               ctl.prev_we[0] = 1'b1;
               prev_data[0]   = lnk_b;
               ctl.next_we[0] = 1'b1;
               next_data[0]   = next_b;
               ctl.next_we[1] = 1'b1;
               next_addr[1]   = b_idx;
               next_data[1]   = lnk_a;
               if (!next_b[ID_W]) begin
                  ctl.prev_we[1] = 1'b1;
                  prev_addr[1]   = next_b[ID_W-1:0];
                  prev_data[1]   = lnk_a;
               end
               if (lnk_b == tail) begin
                  new_tail = lnk_a;
               end
            end
         end
         ACT_MOVE, ACT_SPLICE: begin
            if (!a_here || ((action == ACT_SPLICE) && !b_here)) begin
               ctl.status = ST_NOT_FOUND;
            end else if (lnk_a != head) begin
               if (!prev_a[ID_W]) begin
                  ctl.next_we[0] = 1'b1;
                  next_addr[0]   = prev_a[ID_W-1:0];
                  next_data[0]   = mv_n;
               end
               ctl.next_we[1] = 1'b1;
               next_addr[1]   = e_idx;
               next_data[1]   = head;
               if (!mv_n[ID_W]) begin
                  ctl.prev_we[0] = 1'b1;
                  prev_addr[0]   = mv_n[ID_W-1:0];
                  prev_data[0]   = prev_a;
               end
               ctl.prev_we[1] = 1'b1;
               prev_data[1]   = lnk_null;
               if (!head[ID_W]) begin
                  ctl.prev_we[2] = 1'b1;
                  prev_addr[2]   = head[ID_W-1:0];
                  prev_data[2]   = lnk_a;
               end
               if (lnk_e == tail) begin
                  new_tail = prev_a;
               end
               new_head = lnk_a;
            end
         end
         ACT_READ: begin
            if (!a_here) begin
               ctl.status = ST_NOT_FOUND;
            end else begin
               rd_value = value_a;
               if (!next_a[ID_W]) begin
                  ctl.next_exists = 1'b1;
                  rd_next         = next_a[ID_W-1:0];
               end
               if (!prev_a[ID_W]) begin
                  ctl.prev_exists = 1'b1;
                  rd_prev         = prev_a[ID_W-1:0];
               end
            end
         end
         ACT_REMOVE: begin
            if (!a_here) begin
               ctl.status = ST_NOT_FOUND;
            end else begin
               if (!prev_a[ID_W]) begin
                  ctl.next_we[0] = 1'b1;
                  next_addr[0]   = prev_a[ID_W-1:0];
                  next_data[0]   = next_a;
               end
               if (!next_a[ID_W]) begin
                  ctl.prev_we[0] = 1'b1;
                  prev_addr[0]   = next_a[ID_W-1:0];
                  prev_data[0]   = prev_a;
               end
               if (lnk_a == head) begin
                  new_head = next_a;
               end
               if (lnk_a == tail) begin
                  new_tail = prev_a;
               end
               ctl.pres_we   = 1'b1;
               ctl.pres_data = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/idll_checker.sv =====
// ----------------------------------------------------------------------------
// idll_checker
// port-level checks on the list's request and response channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module idll_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [idll_pkg::STATUS_W-1:0]       rsp_status,
   input  logic signed [idll_pkg::VALUE_W-1:0] rsp_read_value,
   input  logic [idll_pkg::ID_FIELD_W-1:0]     rsp_next_id,
   input  logic                                rsp_next_exists,
   input  logic [idll_pkg::ID_FIELD_W-1:0]     rsp_prev_id,
   input  logic                                rsp_prev_exists,
   input  logic [idll_pkg::ID_FIELD_W-1:0]     rsp_head_id,
   input  logic [idll_pkg::ID_FIELD_W-1:0]     rsp_tail_id,
   input  logic                                rsp_list_empty
);

   import idll_pkg::*;

   logic [STATUS_W+VALUE_W+4*ID_FIELD_W+2:0] rsp_word;
   logic rsp_held;
   logic rsp_empty;
   logic rsp_fail;
   logic ids_zero;
   logic no_data;

   assign rsp_word  = {rsp_status, rsp_read_value, rsp_next_id, rsp_next_exists,
                       rsp_prev_id, rsp_prev_exists, rsp_head_id, rsp_tail_id,
                       rsp_list_empty};
   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_empty = rsp_valid && rsp_list_empty;
   assign rsp_fail  = rsp_valid && (rsp_status != ST_DONE);
   assign ids_zero  = (rsp_head_id == '0) && (rsp_tail_id == '0);
   assign no_data   = (rsp_read_value == '0) && !rsp_next_exists && !rsp_prev_exists;

   `IDLL_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> req_stall)
   `IDLL_ASSERT(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)
   `IDLL_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> (rsp_valid && $stable(rsp_word)))
   `IDLL_ASSERT(a_empty_ids, clock, reset, rsp_empty |-> ids_zero)
   `IDLL_ASSERT(a_fail_no_data, clock, reset, rsp_fail |-> no_data)

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (.*);

`default_nettype wire
